// ----- sv/json_string_unescape_utf8_macros.svh -----
// Assertion helpers, included by json_string_unescape_utf8.sv.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// Same-cycle implication, clocked on clock, disabled in reset.
`define JSU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, disabled in reset.
`define JSU_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/jsu_pkg.sv -----
package jsu_pkg;

   typedef enum logic [5:0] {
      PH_IDLE = 6'b000001,
      PH_BODY = 6'b000010,
      PH_ESC  = 6'b000100,
      PH_HEX  = 6'b001000,
      PH_LOW  = 6'b010000,
      PH_CONT = 6'b100000
   } phase_type;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_SYN = 2'd1;
   localparam logic [1:0] ST_INV = 2'd2;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSL   = 8'h5c;
   localparam logic [7:0] CH_SLASH = 8'h2f;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_F     = 8'h66;
   localparam logic [7:0] CH_N     = 8'h6e;
   localparam logic [7:0] CH_R     = 8'h72;
   localparam logic [7:0] CH_T     = 8'h74;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_SPACE = 8'h20;

   localparam logic [20:0] HI_SURR_MIN = 21'h00d800;
   localparam logic [20:0] HI_SURR_MAX = 21'h00dbff;
   localparam logic [20:0] LO_SURR_MIN = 21'h00dc00;
   localparam logic [20:0] LO_SURR_MAX = 21'h00dfff;
   localparam logic [20:0] SUPP_BASE   = 21'h010000;
   localparam logic [20:0] CODE_MAX    = 21'h10ffff;

   // One queue entry: everything a single input byte produced.
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            has_bytes;
      logic            done;
      logic [1:0]      status;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
   } utf8_enc_type;

   function automatic logic hex_ok(input logic [7:0] c);
      hex_ok = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
               (c >= 8'h41 && c <= 8'h46);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] t;
      t = 8'h00;
      if (c >= 8'h30 && c <= 8'h39) t = c - 8'h30;
      else if (c >= 8'h61 && c <= 8'h66) t = c - 8'h57;
      else if (c >= 8'h41 && c <= 8'h46) t = c - 8'h37;
      hex_val = t[3:0];
   endfunction

   function automatic utf8_enc_type utf8_encode(input logic [20:0] s);
      utf8_enc_type e;
      e = '0;
      if (s <= 21'h7f) begin
         e.bytes[0] = s[7:0];
         e.last_idx = 2'd0;
      end else if (s <= 21'h7ff) begin
         e.bytes[0] = {3'b110, s[10:6]};
         e.bytes[1] = {2'b10, s[5:0]};
         e.last_idx = 2'd1;
      end else if (s <= 21'hffff) begin
         e.bytes[0] = {4'b1110, s[15:12]};
         e.bytes[1] = {2'b10, s[11:6]};
         e.bytes[2] = {2'b10, s[5:0]};
         e.last_idx = 2'd2;
      end else begin
         e.bytes[0] = {5'b11110, s[20:18]};
         e.bytes[1] = {2'b10, s[17:12]};
         e.bytes[2] = {2'b10, s[11:6]};
         e.bytes[3] = {2'b10, s[5:0]};
         e.last_idx = 2'd3;
      end
      utf8_encode = e;
   endfunction

endpackage

// ----- sv/jsu_req_if.sv -----
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, data_byte, end_of_input, input ready);
   modport sink   (input valid, data_byte, end_of_input, output ready);
endinterface

// ----- sv/jsu_rsp_if.sv -----
interface jsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       last_of_run;
   logic       string_done;
   logic [1:0] status;

   modport source (output valid, out_byte, byte_valid, last_of_run, string_done, status,
                   input ready);
   modport sink   (input valid, out_byte, byte_valid, last_of_run, string_done, status,
                   output ready);
endinterface

// ----- sv/jsu_front.sv -----
module jsu_front (
   input  logic               clock,
   input  logic               reset,
   jsu_req_if.sink            req_ch,
   input  logic               queue_full,
   output logic               push_valid,
   output jsu_pkg::run_type   push_data
);
   import jsu_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [20:0] acc_ff, acc_in;
   logic [9:0]  hs_ff, hs_in;
   logic [2:0]  dl_ff, dl_in;
   logic [1:0]  mc_ff, mc_in;
   logic [1:0]  he_ff, he_in;

   logic         accept;
   logic         done;
   logic [1:0]   st;
   logic         emit;
   utf8_enc_type enc;
   logic [2:0]   dl_t;
   logic [2:0]   k;
   logic [20:0]  mn;
   logic [7:0]   b;
   logic         eoi;

   assign req_ch.ready = !queue_full;
   assign accept       = req_ch.valid && !queue_full;
   assign b            = req_ch.data_byte;
   assign eoi          = req_ch.end_of_input;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      hs_in    = hs_ff;
      dl_in    = dl_ff;
      mc_in    = mc_ff;
      he_in    = he_ff;
      done     = 1'b0;
      st       = ST_OK;
      emit     = 1'b0;
      enc      = '0;
      dl_t     = dl_ff;
      k        = 3'd0;
      mn       = SUPP_BASE;
      case (phase_ff)
         PH_BODY: begin
            if (b == CH_QUOTE) begin
               done = 1'b1;
            end else if (b < CH_SPACE) begin
               done = 1'b1;
               st   = ST_SYN;
            end else if (b == CH_BSL) begin
               phase_in = PH_ESC;
               if (eoi) begin
                  done = 1'b1;
                  st   = ST_SYN;
               end
            end else if (b < 8'h80) begin
               emit         = 1'b1;
               enc.bytes[0] = b;
               if (eoi) begin
                  done = 1'b1;
                  st   = ST_SYN;
               end
            end else if (b inside {[8'hc2:8'hdf]}) begin
               acc_in   = {16'd0, b[4:0]};
               dl_in    = 3'd1;
               mc_in    = 2'd1;
               phase_in = PH_CONT;
            end else if (b inside {[8'he0:8'hef]}) begin
               acc_in   = {17'd0, b[3:0]};
               dl_in    = 3'd2;
               mc_in    = 2'd2;
               phase_in = PH_CONT;
            end else if (b inside {[8'hf0:8'hf4]}) begin
               acc_in   = {18'd0, b[2:0]};
               dl_in    = 3'd3;
               mc_in    = 2'd3;
               phase_in = PH_CONT;
            end else begin
               done = 1'b1;
               st   = ST_INV;
            end
            if (!done && phase_in == PH_CONT && eoi) begin
               done = 1'b1;
               st   = ST_INV;
            end
         end
         PH_ESC: begin
            phase_in = PH_BODY;
            case (b)
               CH_QUOTE, CH_BSL, CH_SLASH: begin
                  emit = 1'b1;
                  enc.bytes[0] = b;
               end
               CH_B: begin
                  emit = 1'b1;
                  enc.bytes[0] = 8'h08;
               end
               CH_F: begin
                  emit = 1'b1;
                  enc.bytes[0] = 8'h0c;
               end
               CH_N: begin
                  emit = 1'b1;
                  enc.bytes[0] = 8'h0a;
               end
               CH_R: begin
                  emit = 1'b1;
                  enc.bytes[0] = 8'h0d;
               end
               CH_T: begin
                  emit = 1'b1;
                  enc.bytes[0] = 8'h09;
               end
               CH_U: begin
                  phase_in = PH_HEX;
                  acc_in   = '0;
                  dl_in    = 3'd4;
               end
               default: begin
                  done = 1'b1;
                  st   = ST_SYN;
               end
            endcase
            if (!done && eoi) begin
               done = 1'b1;
               st   = ST_SYN;
            end
         end
         PH_HEX: begin
            if (!hex_ok(b)) begin
               done = 1'b1;
               st   = ST_SYN;
            end else begin
               acc_in = {5'd0, acc_ff[11:0], hex_val(b)};
               dl_in  = dl_ff - 3'd1;
               if (dl_in != 3'd0) begin
                  if (eoi) begin
                     done = 1'b1;
                     st   = ST_SYN;
                  end
               end else if (acc_in >= HI_SURR_MIN && acc_in <= HI_SURR_MAX) begin
                  hs_in    = acc_in[9:0];
                  acc_in   = '0;
                  dl_in    = 3'd6;
                  he_in    = ST_OK;
                  phase_in = PH_LOW;
                  if (eoi) begin
                     done = 1'b1;
                     st   = ST_INV;
                  end
               end else if (acc_in >= LO_SURR_MIN && acc_in <= LO_SURR_MAX) begin
                  done = 1'b1;
                  st   = ST_INV;
               end else begin
                  emit     = 1'b1;
                  enc      = utf8_encode(acc_in);
                  phase_in = PH_BODY;
                  if (eoi) begin
                     done = 1'b1;
                     st   = ST_SYN;
                  end
               end
            end
         end
         PH_LOW: begin
            dl_t = (dl_ff == 3'd0 || dl_ff > 3'd6) ? 3'd6 : dl_ff;
            k    = 3'd6 - dl_t;
            if (he_ff == ST_OK) begin
               if (k == 3'd0) begin
                  if (b != CH_BSL) he_in = ST_INV;
               end else if (k == 3'd1) begin
                  if (b != CH_U) he_in = ST_INV;
               end else if (!hex_ok(b)) begin
                  he_in = ST_SYN;
               end else begin
                  acc_in = {5'd0, acc_ff[11:0], hex_val(b)};
               end
            end
            dl_in = dl_t - 3'd1;
            if (dl_in != 3'd0) begin
               if (eoi) begin
                  done = 1'b1;
                  st   = ST_INV;
               end
            end else begin
               if (he_in == ST_OK && (acc_in < LO_SURR_MIN || acc_in > LO_SURR_MAX))
                  he_in = ST_INV;
               if (he_in != ST_OK) begin
                  done = 1'b1;
                  st   = he_in;
               end else begin
                  emit     = 1'b1;
                  enc      = utf8_encode(SUPP_BASE + {1'b0, hs_ff, acc_in[9:0]});
                  phase_in = PH_BODY;
                  if (eoi) begin
                     done = 1'b1;
                     st   = ST_SYN;
                  end
               end
            end
         end
         PH_CONT: begin
            if (b[7:6] != 2'b10) begin
               done = 1'b1;
               st   = ST_INV;
            end else begin
               acc_in = {acc_ff[14:0], b[5:0]};
               dl_in  = dl_ff - 3'd1;
               if (dl_in != 3'd0 && dl_in < 3'd4) begin
                  if (eoi) begin
                     done = 1'b1;
                     st   = ST_INV;
                  end
               end else begin
                  mn = (mc_ff == 2'd1) ? 21'h80 : (mc_ff == 2'd2) ? 21'h800 : SUPP_BASE;
                  if (acc_in < mn || acc_in > CODE_MAX ||
                      (acc_in >= HI_SURR_MIN && acc_in <= LO_SURR_MAX)) begin
                     done = 1'b1;
                     st   = ST_INV;
                  end else begin
                     emit     = 1'b1;
                     enc      = utf8_encode(acc_in);
                     phase_in = PH_BODY;
                     if (eoi) begin
                        done = 1'b1;
                        st   = ST_SYN;
                     end
                  end
               end
            end
         end
         default: begin
            // idle, and any code that should never appear
            if (b == CH_QUOTE) begin
               acc_in   = '0;
               hs_in    = '0;
               dl_in    = '0;
               mc_in    = '0;
               he_in    = ST_OK;
               phase_in = PH_BODY;
               if (eoi) begin
                  done = 1'b1;
                  st   = ST_SYN;
               end
            end else begin
               done = 1'b1;
               st   = ST_SYN;
            end
         end
      endcase
      if (done) begin
         phase_in = PH_IDLE;
         acc_in   = '0;
         hs_in    = '0;
         dl_in    = '0;
         mc_in    = '0;
         he_in    = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         acc_ff   <= '0;
         hs_ff    <= '0;
         dl_ff    <= '0;
         mc_ff    <= '0;
         he_ff    <= ST_OK;
      end else if (accept) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         hs_ff    <= hs_in;
         dl_ff    <= dl_in;
         mc_ff    <= mc_in;
         he_ff    <= he_in;
      end
   end

   assign push_valid          = accept && (emit || done);
   assign push_data.bytes     = enc.bytes;
   assign push_data.last_idx  = emit ? enc.last_idx : 2'd0;
   assign push_data.has_bytes = emit;
   assign push_data.done      = done;
   assign push_data.status    = st;

endmodule

// ----- sv/jsu_fifo.sv -----
module jsu_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  jsu_pkg::run_type        push_data,
   input  logic                    pop,
   output jsu_pkg::run_type        head,
   output jsu_pkg::fifo_stat_type  stat
);
   import jsu_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

   run_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign stat.full  = (count_ff == CNT_FULL);
   assign stat.empty = (count_ff == '0);
   assign do_push    = push_valid && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ----- sv/jsu_back.sv -----
module jsu_back (
   input  logic                    clock,
   input  logic                    reset,
   input  jsu_pkg::run_type        head,
   input  jsu_pkg::fifo_stat_type  stat,
   output logic                    pop,
   jsu_rsp_if.source               rsp_ch
);
   import jsu_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;
   logic       xfer;

   assign last = (idx_ff == head.last_idx);
   assign xfer = rsp_ch.valid && rsp_ch.ready;
   assign pop  = xfer && last;

   assign rsp_ch.valid       = !stat.empty;
   assign rsp_ch.out_byte    = head.has_bytes ? head.bytes[idx_ff] : 8'h00;
   assign rsp_ch.byte_valid  = head.has_bytes;
   assign rsp_ch.last_of_run = last;
   assign rsp_ch.string_done = last && head.done;
   assign rsp_ch.status      = (last && head.done) ? head.status : ST_OK;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) idx_in = last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

// ----- sv/json_string_unescape_utf8.sv -----
// JSON string unescaper with UTF-8 validation.
// req_ch takes one raw byte of a JSON string token per transfer, starting at the
// opening quote, with end_of_input flagging the last byte available.
// rsp_ch gives the decoded UTF-8 bytes, one per transfer. Each input byte yields
// zero to four result transfers; last_of_run marks the final one, and
// string_done/status mark the close (ok) or the first error (syntax, invalid UTF-8).
// A done report with no byte is a single transfer with byte_valid low.
// Each input byte's run is queued as the byte transfers and offered after the runs ahead of it.
// Throughput: one input byte per cycle; one output byte per cycle, set by the
// serializer that walks each queued run. The decoder never produces more bytes
// than it has consumed over a run, so the run queue (QUEUE_DEPTH entries) keeps
// input flowing at one byte per cycle while the receiver takes every transfer.
// When the receiver stalls, runs collect in the queue; once it is full req_ch.ready
// drops, and rises again the cycle after the receiver takes the head run's final byte.
// Reset (synchronous, active high) puts the decoder back to waiting for a quote
// and empties the queue; no clearing pass is needed.
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 #(
   parameter int QUEUE_DEPTH = 5
) (
   input  logic       clock,
   input  logic       reset,
   jsu_req_if.sink    req_ch,
   jsu_rsp_if.source  rsp_ch
);
   import jsu_pkg::*;

   logic          push_valid;
   run_type       push_data;
   run_type       head;
   fifo_stat_type stat;
   logic          pop;

   // front: decode state machine, one byte per cycle while the queue is not full, at most one run record per byte
   jsu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .queue_full (stat.full),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // run queue between decoder and serializer
   jsu_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   // back: walks each run out a byte at a time
   jsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .stat   (stat),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

   // decoder must never push into a full queue
   `JSU_ASSERT_IMP(a_no_push_full, push_valid, !stat.full, "push into full run queue")
   // a done report always sits on the last transfer of its run
   `JSU_ASSERT_IMP(a_done_last, rsp_ch.valid && rsp_ch.string_done, rsp_ch.last_of_run,
      "string_done off the last transfer")
   // nonzero status only comes with a done report
   `JSU_ASSERT_IMP(a_status_done, rsp_ch.valid && !rsp_ch.string_done,
      rsp_ch.status == ST_OK, "status without string_done")
   // a transfer without a byte is a bare done report
   `JSU_ASSERT_IMP(a_empty_is_done, rsp_ch.valid && !rsp_ch.byte_valid,
      rsp_ch.string_done && rsp_ch.out_byte == 8'h00, "empty transfer not a done report")

endmodule

// ----- test/tb_json_string_unescape_utf8.sv -----
`timescale 1ns / 100ps

module tb_json_string_unescape_utf8;
   import jsu_pkg::*;

   localparam int RANDOM_BYTES = 24;
   localparam int HOLD_LEN     = 80;       // long receiver stall, in cycles
   localparam int CYCLE_LIMIT  = 200000;   // run timeout
   localparam int TAIL_CYCLES  = 12;       // settle time after the last result

   // One result transfer, laid out in port order.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       last_of_run;
      logic       string_done;
      logic [1:0] status;
   } dec_result_type;

   // Scoreboard: a bit-accurate decoder that predicts the result transfers of each
   // accepted byte, plus the in-order check of what the block returns.
   class utf8_unescape_checker;
      phase_type   ph;
      logic [20:0] acc;
      logic [9:0]  hi_half;
      logic [2:0]  left;
      logic [1:0]  min_class;
      logic [1:0]  held;

      dec_result_type decoded_q[$];
      bit             string_closed;
      int             errors, bytes_in, results_out, n_ok, n_syn, n_inv;

      function new();
         clear_state();
      endfunction

      function void clear_state();
         ph        = PH_IDLE;
         acc       = '0;
         hi_half   = '0;
         left      = '0;
         min_class = '0;
         held      = ST_OK;
      endfunction

      static function int hex_digit(input logic [7:0] c);
         if (c >= "0" && c <= "9") return int'(c) - 48;
         if (c >= "a" && c <= "f") return int'(c) - 87;
         if (c >= "A" && c <= "F") return int'(c) - 55;
         return -1;
      endfunction

      static function void put_utf8(input logic [20:0] cp, ref logic [7:0] q[$]);
         if (cp < 21'h80) begin
            q.insert(q.size(), cp[7:0]);
         end else if (cp < 21'h800) begin
            q.insert(q.size(), {3'b110, cp[10:6]});
            q.insert(q.size(), {2'b10, cp[5:0]});
         end else if (cp < SUPP_BASE) begin
            q.insert(q.size(), {4'b1110, cp[15:12]});
            q.insert(q.size(), {2'b10, cp[11:6]});
            q.insert(q.size(), {2'b10, cp[5:0]});
         end else begin
            q.insert(q.size(), {5'b11110, cp[20:18]});
            q.insert(q.size(), {2'b10, cp[17:12]});
            q.insert(q.size(), {2'b10, cp[11:6]});
            q.insert(q.size(), {2'b10, cp[5:0]});
         end
      endfunction

      // Advance the decoder by one accepted byte and queue what it produces.
      function void decode_byte(input logic [7:0] b, input logic eoi);
         logic [7:0]     emit[$];
         bit             done;
         logic [1:0]     st;
         int             h, k, n;
         logic [20:0]    floor_v;
         dec_result_type r;
         done = 0;
         st   = ST_OK;
         bytes_in++;
         case (ph)
            PH_BODY: begin
               if (b == CH_QUOTE) begin
                  done = 1;
               end else if (b < CH_SPACE) begin
                  done = 1; st = ST_SYN;
               end else if (b == CH_BSL) begin
                  ph = PH_ESC;
                  if (eoi) begin done = 1; st = ST_SYN; end
               end else if (b < 8'h80) begin
                  emit.insert(emit.size(), b);
                  if (eoi) begin done = 1; st = ST_SYN; end
               end else if (b >= 8'hc2 && b <= 8'hdf) begin
                  acc = 21'(b[4:0]); left = 3'd1; min_class = 2'd1; ph = PH_CONT;
               end else if (b >= 8'he0 && b <= 8'hef) begin
                  acc = 21'(b[3:0]); left = 3'd2; min_class = 2'd2; ph = PH_CONT;
               end else if (b >= 8'hf0 && b <= 8'hf4) begin
                  acc = 21'(b[2:0]); left = 3'd3; min_class = 2'd3; ph = PH_CONT;
               end else begin
                  done = 1; st = ST_INV;
               end
               // a lead byte that is also the last byte leaves a sequence unfinished
               if (!done && ph == PH_CONT && eoi) begin done = 1; st = ST_INV; end
            end
            PH_ESC: begin
               ph = PH_BODY;
               case (b)
                  CH_QUOTE, CH_BSL, CH_SLASH: emit.insert(emit.size(), b);
                  CH_B: emit.insert(emit.size(), 8'h08);
                  CH_F: emit.insert(emit.size(), 8'h0c);
                  CH_N: emit.insert(emit.size(), 8'h0a);
                  CH_R: emit.insert(emit.size(), 8'h0d);
                  CH_T: emit.insert(emit.size(), 8'h09);
                  CH_U: begin
                     ph = PH_HEX; acc = '0; left = 3'd4;
                  end
                  default: begin done = 1; st = ST_SYN; end
               endcase
               if (!done && eoi) begin done = 1; st = ST_SYN; end
            end
            PH_HEX: begin
               h = hex_digit(b);
               if (h < 0) begin
                  done = 1; st = ST_SYN;
               end else begin
                  acc  = {5'b0, acc[11:0], 4'(h)};
                  left = left - 3'd1;
                  if (left != 0) begin
                     if (eoi) begin done = 1; st = ST_SYN; end
                  end else if (acc >= HI_SURR_MIN && acc <= HI_SURR_MAX) begin
                     hi_half = 10'(acc - HI_SURR_MIN);
                     acc = '0; left = 3'd6; held = ST_OK; ph = PH_LOW;
                     if (eoi) begin done = 1; st = ST_INV; end
                  end else if (acc >= LO_SURR_MIN && acc <= LO_SURR_MAX) begin
                     done = 1; st = ST_INV;
                  end else begin
                     put_utf8(acc, emit);
                     ph = PH_BODY;
                     if (eoi) begin done = 1; st = ST_SYN; end
                  end
               end
            end
            PH_LOW: begin
               // six bytes are taken unless the input ends first; the first error is held until the sixth
               if (left == 0 || left > 3'd6) left = 3'd6;
               k = 6 - int'(left);
               if (held == ST_OK) begin
                  if (k == 0) begin
                     if (b != CH_BSL) held = ST_INV;
                  end else if (k == 1) begin
                     if (b != CH_U) held = ST_INV;
                  end else begin
                     h = hex_digit(b);
                     if (h < 0) held = ST_SYN;
                     else acc = {5'b0, acc[11:0], 4'(h)};
                  end
               end
               left = left - 3'd1;
               if (left != 0) begin
                  if (eoi) begin done = 1; st = ST_INV; end
               end else begin
                  if (held == ST_OK && (acc < LO_SURR_MIN || acc > LO_SURR_MAX))
                     held = ST_INV;
                  if (held != ST_OK) begin
                     done = 1; st = held;
                  end else begin
                     put_utf8(SUPP_BASE + 21'({hi_half, 10'b0}) + (acc - LO_SURR_MIN),
                              emit);
                     ph = PH_BODY;
                     if (eoi) begin done = 1; st = ST_SYN; end
                  end
               end
            end
            PH_CONT: begin
               if (b[7:6] != 2'b10) begin
                  done = 1; st = ST_INV;
               end else begin
                  acc  = {acc[14:0], b[5:0]};
                  left = left - 3'd1;
                  if (left != 0 && left < 3'd4) begin
                     if (eoi) begin done = 1; st = ST_INV; end
                  end else begin
                     floor_v = (min_class == 2'd1) ? 21'h80 :
                               (min_class == 2'd2) ? 21'h800 : SUPP_BASE;
                     if (acc < floor_v || acc > CODE_MAX ||
                         (acc >= HI_SURR_MIN && acc <= LO_SURR_MAX)) begin
                        done = 1; st = ST_INV;
                     end else begin
                        put_utf8(acc, emit);
                        ph = PH_BODY;
                        if (eoi) begin done = 1; st = ST_SYN; end
                     end
                  end
               end
            end
            default: begin
               if (b == CH_QUOTE) begin
                  clear_state();
                  ph = PH_BODY;
                  if (eoi) begin done = 1; st = ST_SYN; end
               end else begin
                  done = 1; st = ST_SYN;
               end
            end
         endcase

         if (done) begin
            clear_state();
            case (st)
               ST_OK:   n_ok++;
               ST_SYN:  n_syn++;
               default: n_inv++;
            endcase
         end
         string_closed = done;

         if (emit.size() == 0 && !done) return;
         n = (emit.size() == 0) ? 1 : emit.size();
         for (int i = 0; i < n; i++) begin
            r.out_byte    = (emit.size() == 0) ? 8'h00 : emit[i];
            r.byte_valid  = (emit.size() != 0);
            r.last_of_run = (i == n - 1);
            r.string_done = (i == n - 1) && done;
            r.status      = ((i == n - 1) && done) ? st : ST_OK;
            decoded_q.insert(decoded_q.size(), r);
         end
      endfunction

      function void check_decoded(input dec_result_type got);
         dec_result_type want;
         bit             bad;
         results_out++;
         if (decoded_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result: byte %h valid %b last %b done %b status %0d",
                     $time, got.out_byte, got.byte_valid, got.last_of_run,
                     got.string_done, got.status);
            return;
         end
         want = decoded_q.pop_front();
         bad = 0;
         if (got.out_byte    !== want.out_byte)    bad = 1;
         if (got.byte_valid  !== want.byte_valid)  bad = 1;
         if (got.last_of_run !== want.last_of_run) bad = 1;
         if (got.string_done !== want.string_done) bad = 1;
         if (got.status      !== want.status)      bad = 1;
         if (bad) begin
            errors++;
            $display("%0t: mismatch: expected byte %h valid %b last %b done %b status %0d",
                     $time, want.out_byte, want.byte_valid, want.last_of_run,
                     want.string_done, want.status);
            $display("%0t:           actual byte %h valid %b last %b done %b status %0d",
                     $time, got.out_byte, got.byte_valid, got.last_of_run,
                     got.string_done, got.status);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   jsu_req_if req_ch ();
   jsu_rsp_if rsp_ch ();

   json_string_unescape_utf8 dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   utf8_unescape_checker sb;

   logic [7:0] tok[$];        // bytes of the token being sent
   bit         gaps_on;       // random idling on both sides
   int         hold_asked;    // bumped by the stimulus to request a long stall
   int         hold_taken;
   int         hold_left;
   int         cycles;

   logic [7:0] esc_chars[8] = '{CH_QUOTE, CH_BSL, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timeout watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off counted here when the stimulus
   // asks for one, so the block's run queue fills and req_ch.ready drops.
   always @(posedge clock) begin
      if (hold_asked != hold_taken) begin
         hold_taken = hold_asked;
         hold_left  = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 17);
      end
   end

   // Both channels are sampled mid-cycle, where everything driven at the rising
   // edge has settled; a transfer seen here completes at the next rising edge.
   // The input is noted before the result check, and a result is registered in
   // the run queue before it is offered, so the expectation is always in place first.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready)
            sb.decode_byte(req_ch.data_byte, req_ch.end_of_input);
         if (rsp_ch.valid && rsp_ch.ready)
            sb.check_decoded({rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.last_of_run,
                              rsp_ch.string_done, rsp_ch.status});
      end
   end

   // Offer one byte; returns at the rising edge where it transfers.
   task automatic send_byte(input logic [7:0] b, input logic eoi);
      bit taken;
      while (gaps_on && $urandom_range(99) < 17) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.data_byte    <= b;
      req_ch.end_of_input <= eoi;
      do begin
         @(negedge clock);
         taken = req_ch.ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Send tok; stop early once the string has closed or failed so that the
   // leftover bytes are not fed to the quote hunt.
   task automatic send_token(input bit eoi_last);
      for (int i = 0; i < tok.size(); i++) begin
         send_byte(tok[i], eoi_last && (i == tok.size() - 1));
         if (sb.string_closed) break;
      end
      tok.delete();
   endtask

   function automatic void put(input string s);
      for (int i = 0; i < s.len(); i++) tok.insert(tok.size(), s[i]);
   endfunction

   task automatic directed(input string s, input bit eoi_last);
      put(s);
      send_token(eoi_last);
   endtask

   // Four hex digits, case picked at random.
   function automatic void put_hex16(input logic [15:0] v);
      logic [3:0] d;
      for (int i = 3; i >= 0; i--) begin
         d = v[i*4 +: 4];
         if (d < 4'd10) tok.insert(tok.size(), 8'h30 + 8'(d));
         else tok.insert(tok.size(), ($urandom_range(1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10);
      end
   endfunction

   // Mostly well-formed strings with random content; about a third are
   // corrupted, cut short or closed with end_of_input.
   task automatic build_random_token(output bit eoi_last);
      logic [20:0] cp;
      logic [7:0]  c;
      int          segs, r, pos;
      eoi_last = 0;
      tok.insert(tok.size(), CH_QUOTE);
      segs = $urandom_range(4, 1);
      for (int s = 0; s < segs; s++) begin
         r = $urandom_range(9);
         if (r <= 2 || r == 9) begin
            for (int j = $urandom_range(3, 1); j > 0; j--) begin
               c = 8'($urandom_range(127, 32));
               if (c == CH_QUOTE || c == CH_BSL) c = 8'h61;
               tok.insert(tok.size(), c);
            end
         end else if (r == 3) begin
            tok.insert(tok.size(), CH_BSL);
            tok.insert(tok.size(), esc_chars[$urandom_range(7)]);
         end else if (r == 4) begin
            case ($urandom_range(2))
               0:       cp = 21'($urandom_range(16'h7f));
               1:       cp = 21'($urandom_range(16'h7ff, 16'h80));
               default: cp = 21'($urandom_range(16'hffff, 16'h800));
            endcase
            if (cp >= HI_SURR_MIN && cp <= LO_SURR_MAX) cp = cp ^ 21'h4000;
            tok.insert(tok.size(), CH_BSL); tok.insert(tok.size(), CH_U);
            put_hex16(cp[15:0]);
         end else if (r == 5) begin
            tok.insert(tok.size(), CH_BSL); tok.insert(tok.size(), CH_U);
            put_hex16(16'hd800 + 16'($urandom_range(10'h3ff)));
            tok.insert(tok.size(), CH_BSL); tok.insert(tok.size(), CH_U);
            put_hex16(16'hdc00 + 16'($urandom_range(10'h3ff)));
         end else begin
            case (r)
               6:       cp = 21'($urandom_range(21'h7ff, 21'h80));
               7:       cp = 21'($urandom_range(21'hffff, 21'h800));
               default: cp = 21'($urandom_range(21'h10ffff, 21'h10000));
            endcase
            if (cp >= HI_SURR_MIN && cp <= LO_SURR_MAX) cp = cp ^ 21'h4000;
            utf8_unescape_checker::put_utf8(cp, tok);
         end
      end
      tok.insert(tok.size(), CH_QUOTE);

      // A missing or wrong opening quote now and then.
      if ($urandom_range(99) < 8) tok[0] = 8'($urandom_range(255));
      r = $urandom_range(99);
      if (r < 12) begin
         tok[$urandom_range(tok.size() - 1, 1)] = 8'($urandom_range(255));
      end else if (r < 20) begin
         pos = $urandom_range(tok.size() - 1);
         while (tok.size() > pos + 1) void'(tok.pop_back());
         eoi_last = 1;
      end else if (r < 24) begin
         eoi_last = 1;
      end else if (r < 28) begin
         tok.insert($urandom_range(tok.size() - 1, 1), 8'($urandom_range(31)));
      end
   endtask

   // Sender pause until every predicted result has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (sb.decoded_q.size() != 0);
   endtask

   initial begin
      bit eoi_last;
      int start_bytes;
      int t;
      sb = new();
      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.data_byte    = 8'h00;
      req_ch.end_of_input = 1'b0;
      rsp_ch.ready        = 1'b0;
      gaps_on             = 1'b1;
      hold_asked          = 0;
      hold_taken          = 0;
      hold_left           = 0;
      cycles              = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Well-formed strings: empty, DEL and every short escape, U+0000, the largest
      // surrogate pair, and raw UTF-8 at the top of the two- and four-byte forms.
      directed("\"\"", 0);
      directed("\"\177\\\"\\\\\\/\\b\\f\\n\\r\\t\"", 0);
      directed("\"\\u0000\\uDBFF\\uDFFF\337\277\364\217\277\277\"", 0);

      // Long receiver stall while the sender keeps offering plain bytes.
      hold_asked++;
      directed("\"abcdefgh\"", 0);

      // From here through the early-end cases neither side idles.
      gaps_on = 1'b0;

      // Syntax errors: no opening quote, unknown escape, bad hex digit, control byte.
      directed("x", 0);
      directed("\"\\q", 0);
      directed("\"\\ug", 0);
      directed("\"\001", 0);

      // Raw UTF-8 errors: bad leads, bad continuation, overlong, surrogate, > U+10FFFF.
      directed("\"\200", 0);
      directed("\"\300", 0);
      directed("\"\365", 0);
      directed("\"\303A", 0);
      directed("\"\340\200\200", 0);
      directed("\"\355\240\200", 0);
      directed("\"\364\220\200\200", 0);

      // Surrogate handling: lone low half, and errors held over the six bytes
      // after a high half (no backslash, bad hex, low half out of range).
      directed("\"\\uDC00", 0);
      directed("\"\\uD800abcdef", 0);
      directed("\"\\uD800\\uDC0g", 0);
      directed("\"\\uD800\\u0041", 0);

      // Input ending early, in several phases, including a step that still emits.
      directed("\"ab", 1);
      directed("\"\\", 1);
      directed("\"\\u00", 1);
      directed("\"\342\202", 1);
      directed("\"\\uD800x", 1);
      wait_drained();

      // Random strings with idling on both sides; the sender waits for a full
      // drain every other token.
      gaps_on = 1'b1;
      start_bytes = sb.bytes_in;
      t = 0;
      while (sb.bytes_in - start_bytes < RANDOM_BYTES) begin
         if (t % 2 == 1) wait_drained();
         build_random_token(eoi_last);
         send_token(eoi_last);
         t++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d input bytes as %0d strings: %0d closed ok, %0d syntax, %0d bad UTF-8",
               sb.bytes_in, sb.n_ok + sb.n_syn + sb.n_inv, sb.n_ok, sb.n_syn, sb.n_inv);
      $display("Checked %0d result transfers, %0d still awaited, %0d mismatches",
               sb.results_out, sb.decoded_q.size(), sb.errors);
      if (sb.errors == 0 && sb.decoded_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
